### hw/rtl/zpd_pkg.sv
`timescale 1ns / 1ps
// zpd_pkg: payload types, register codes and the microprogram ROM of the
// z-score peak detector. No dependencies.
package zpd_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COUNT_WIDTH    = 16;
    localparam int THRESHOLD_W    = 8;
    localparam int INFLUENCE_W    = 9;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_INDEX_W    = 1;
    localparam int THR_SQ_W       = 2 * THRESHOLD_W;
    localparam int BLEND_SHIFT    = 8;   // Q1.8 influence
    localparam int LHS_SHIFT      = 8;   // 16^2 from the Q4.4 threshold
    localparam int ROUND_HALF     = 128;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INFLUENCE = 1'b1;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd48;
    localparam logic [THR_SQ_W-1:0]    THR_SQ_RESET    = 16'd2304;
    localparam logic [INFLUENCE_W-1:0] INFLUENCE_RESET = 9'd0;
    localparam logic [INFLUENCE_W-1:0] INFLUENCE_ONE   = 9'd256;
    localparam logic [COUNT_WIDTH-1:0] RISE_MAX        = 16'hFFFF;

    localparam logic signed [1:0] SIG_ZERO = 2'sb00;
    localparam logic signed [1:0] SIG_POS  = 2'sb01;
    localparam logic signed [1:0] SIG_NEG  = 2'sb11;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           frame_start;
    } zpd_in_t;

    typedef struct packed {
        logic signed [1:0]        peak_signal;
        logic [COUNT_WIDTH-1:0]   peak_count;
        logic                     window_ready;
    } zpd_out_t;

    // Microprogram step counter and step addresses
    typedef logic [3:0] step_t;
    localparam step_t STEP_START  = 4'd0;
    localparam step_t STEP_DIFF   = 4'd1;
    localparam step_t STEP_BLEND  = 4'd2;
    localparam step_t STEP_LHS    = 4'd3;
    localparam step_t STEP_RHS_LO = 4'd4;
    localparam step_t STEP_RHS_HI = 4'd5;
    localparam step_t STEP_CMP    = 4'd6;
    localparam step_t STEP_NEW    = 4'd7;
    localparam step_t STEP_COMMIT = 4'd8;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_SS    = 3'd1,   // sum * sum
        MUL_BLEND = 3'd2,   // influence * (y - last)
        MUL_DD    = 3'd3,   // diff * diff
        MUL_TV_LO = 3'd4,   // thr^2 * spread low half
        MUL_TV_HI = 3'd5,   // thr^2 * spread high half
        MUL_OLD   = 3'd6,   // (L*old) * old
        MUL_NEW   = 3'd7    // (L*v) * v
    } mul_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT    = 2'd0,
        JMP_IF_FILL = 2'd1, // to target while the window is filling
        JMP_END     = 2'd2  // commit result, back to idle
    } jump_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        jump_t    jump;
        step_t    target;
        logic     ld_ly;
        logic     rd_old;
        logic     clr_flag;
        logic     ld_spread;
        logic     ld_diff;
        logic     ld_old;
        logic     ld_f;
        logic     ld_lhs;
        logic     ld_lfb;
        logic     ld_rhs;
        logic     acc_rhs;
        logic     sub_old;
        logic     ld_flag;
        logic     ld_new;
    } uword_t;

    function automatic uword_t ucode_word(input step_t step);
        uword_t w;
        w = '0;
        w.mul_sel = MUL_NONE;
        w.jump    = JMP_NEXT;
        w.target  = STEP_START;
        unique case (step)
            STEP_START: begin
                w.mul_sel  = MUL_SS;
                w.ld_ly    = 1'b1;
                w.rd_old   = 1'b1;
                w.clr_flag = 1'b1;
                w.jump     = JMP_IF_FILL;
                w.target   = STEP_NEW;
            end
            STEP_DIFF: begin
                w.mul_sel   = MUL_BLEND;
                w.ld_spread = 1'b1;
                w.ld_diff   = 1'b1;
                w.ld_old    = 1'b1;
            end
            STEP_BLEND: begin
                w.mul_sel = MUL_DD;
                w.ld_f    = 1'b1;
            end
            STEP_LHS: begin
                w.mul_sel = MUL_TV_LO;
                w.ld_lhs  = 1'b1;
                w.ld_lfb  = 1'b1;
            end
            STEP_RHS_LO: begin
                w.mul_sel = MUL_TV_HI;
                w.ld_rhs  = 1'b1;
            end
            STEP_RHS_HI: begin
                w.mul_sel = MUL_OLD;
                w.acc_rhs = 1'b1;
            end
            STEP_CMP: begin
                w.sub_old = 1'b1;
                w.ld_flag = 1'b1;
            end
            STEP_NEW: begin
                w.mul_sel = MUL_NEW;
                w.ld_new  = 1'b1;
            end
            STEP_COMMIT: begin
                w.jump = JMP_END;
            end
            default: begin
                w.jump = JMP_END;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/zpd_ram.sv
`timescale 1ns / 1ps
// zpd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module zpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/zscore_peak_detector.sv
`timescale 1ns / 1ps
// zscore_peak_detector: smoothed z-score peak detector, microcoded datapath.
// Depends on zpd_pkg (types, microprogram) and zpd_ram (window store).
//
// Usage:
//   s_valid/s_ready/s_data carry one signed sample per transfer; frame_start
//   restarts the window fill and the rise count with that sample.
//   m_valid/m_ready/m_data carry one result per sample: peak_signal (+1/-1/0),
//   peak_count (rises 0 -> +1 this frame, saturating) and window_ready.
//   cfg_wr_en/cfg_index/cfg_wdata write threshold_q4_4 (index 0) and
//   influence_q1_8 (index 1); write only while idle.
// Sequencing:
//   A nine-step microprogram drives one shared multiplier. A sample that
//   fills the window runs 3 steps (START, NEW, COMMIT); a full-window sample
//   runs all 9 steps. A new sample is taken only once the last one commits.
// Reset clears the window, sums, counters and sets the registers to their
// defaults; the window RAM itself is not cleared, each frame refills it.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and processed up to its commit step, where it waits.
module zscore_peak_detector #(
    parameter int WINDOW_LENGTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  zpd_pkg::zpd_in_t                      s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output zpd_pkg::zpd_out_t                     m_data,
    input  logic                                  cfg_wr_en,
    input  logic [zpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [zpd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    // Widths
    localparam int SW   = zpd_pkg::SAMPLE_WIDTH;
    localparam int LB   = $clog2(WINDOW_LENGTH);
    localparam int AW   = (WINDOW_LENGTH > 1) ? LB : 1;
    localparam int FW   = $clog2(WINDOW_LENGTH + 1);
    localparam int SSW  = SW + LB;              // window sum, also L*y
    localparam int DW   = SW + LB + 1;          // L*y - sum
    localparam int VW   = 2 * SW - 1 + 2 * LB;  // L*sumsq and the spread
    localparam int HALF = (VW + 1) / 2;
    localparam int HIW  = VW - HALF;
    localparam int TW   = zpd_pkg::THR_SQ_W;
    localparam int MW0  = (DW > HALF + 1) ? DW : HALF + 1;
    localparam int MW   = (MW0 > TW + 1) ? MW0 : TW + 1;
    localparam int PW   = 2 * MW;
    localparam int LHW  = 2 * DW + 6;
    localparam int RHW  = TW + VW;
    localparam int CW   = (LHW > RHW) ? LHW : RHW;
    localparam logic signed [SSW-1:0] L_S = SSW'(WINDOW_LENGTH);

    // Configuration
    logic [TW-1:0]                      thr_sq_reg;
    logic [zpd_pkg::INFLUENCE_W-1:0]    inf_reg;
    logic [zpd_pkg::INFLUENCE_W-1:0]    inf_eff;

    // Sequencer
    logic                   busy_reg;
    zpd_pkg::step_t         step_reg;
    zpd_pkg::uword_t        uw;
    logic                   out_free;
    logic                   filling;
    logic                   commit;

    // Window state
    logic [AW-1:0]          wptr_reg;
    logic [FW-1:0]          fill_reg;
    logic signed [SSW-1:0]  sum_reg;
    logic [VW-1:0]          lq_reg;
    logic signed [SW-1:0]   lf_reg;
    logic signed [1:0]      prev_reg;
    logic [zpd_pkg::COUNT_WIDTH-1:0] rise_reg;

    // Datapath
    logic signed [SW-1:0]   y_reg;
    logic signed [SSW-1:0]  ly_reg;
    logic signed [DW-1:0]   diff_reg;
    logic [VW-1:0]          spread_reg;
    logic signed [SW-1:0]   old_reg;
    logic signed [SSW-1:0]  lo_reg;
    logic signed [SW-1:0]   f_reg;
    logic signed [SSW-1:0]  lfb_reg;
    logic [CW-1:0]          lhs_reg;
    logic [CW-1:0]          rhs_reg;
    logic                   flag_reg;
    logic signed [SW-1:0]   v_reg;
    logic signed [1:0]      sig_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [SW:0]     blend_diff;
    logic signed [PW-1:0]   p_round;
    logic signed [PW-1:0]   f_wide;
    logic [SW-1:0]          ram_rdata;

    // Commit values
    logic [FW-1:0]          fill_next;
    logic [zpd_pkg::COUNT_WIDTH-1:0] rise_next;
    logic [AW-1:0]          wptr_next;

    logic                   m_valid_reg;
    zpd_pkg::zpd_out_t      m_data_reg;

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign uw       = zpd_pkg::ucode_word(step_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign filling  = (fill_reg < FW'(WINDOW_LENGTH));
    assign commit   = busy_reg && (uw.jump == zpd_pkg::JMP_END) && out_free;
    assign inf_eff  = (inf_reg > zpd_pkg::INFLUENCE_ONE) ? zpd_pkg::INFLUENCE_ONE : inf_reg;

    assign blend_diff = (SW + 1)'(y_reg) - (SW + 1)'(lf_reg);
    assign p_round    = p_reg + $signed(PW'(zpd_pkg::ROUND_HALF));
    // floor((inf*(y-lf) + 128) / 256) added to the last filtered value
    assign f_wide     = PW'(lf_reg) + (p_round >>> zpd_pkg::BLEND_SHIFT);

    assign fill_next = filling ? fill_reg + 1'b1 : fill_reg;
    assign rise_next = (prev_reg == zpd_pkg::SIG_ZERO && sig_reg == zpd_pkg::SIG_POS &&
                        rise_reg != zpd_pkg::RISE_MAX) ? rise_reg + 1'b1 : rise_reg;
    assign wptr_next = (wptr_reg == AW'(WINDOW_LENGTH - 1)) ? '0 : wptr_reg + 1'b1;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uw.mul_sel)
            zpd_pkg::MUL_SS: begin
                mul_a = MW'(sum_reg);
                mul_b = MW'(sum_reg);
            end
            zpd_pkg::MUL_BLEND: begin
                mul_a = $signed(MW'(inf_eff));
                mul_b = MW'(blend_diff);
            end
            zpd_pkg::MUL_DD: begin
                mul_a = MW'(diff_reg);
                mul_b = MW'(diff_reg);
            end
            zpd_pkg::MUL_TV_LO: begin
                mul_a = $signed(MW'(thr_sq_reg));
                mul_b = $signed(MW'(spread_reg[HALF-1:0]));
            end
            zpd_pkg::MUL_TV_HI: begin
                mul_a = $signed(MW'(thr_sq_reg));
                mul_b = $signed(MW'(spread_reg[VW-1:HALF]));
            end
            zpd_pkg::MUL_OLD: begin
                mul_a = MW'(lo_reg);
                mul_b = MW'(old_reg);
            end
            zpd_pkg::MUL_NEW: begin
                mul_a = flag_reg ? MW'(lfb_reg) : MW'(ly_reg);
                mul_b = flag_reg ? MW'(f_reg) : MW'(y_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg <= zpd_pkg::THR_SQ_RESET;
            inf_reg    <= zpd_pkg::INFLUENCE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                zpd_pkg::REG_THRESHOLD: begin
                    thr_sq_reg <= TW'(cfg_wdata[zpd_pkg::THRESHOLD_W-1:0]) *
                                  TW'(cfg_wdata[zpd_pkg::THRESHOLD_W-1:0]);
                end
                zpd_pkg::REG_INFLUENCE: begin
                    inf_reg <= cfg_wdata[zpd_pkg::INFLUENCE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Step counter, window state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= zpd_pkg::STEP_START;
            wptr_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            lq_reg      <= '0;
            lf_reg      <= '0;
            prev_reg    <= zpd_pkg::SIG_ZERO;
            rise_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            if (s_valid && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= zpd_pkg::STEP_START;
                if (s_data.frame_start) begin
                    wptr_reg <= '0;
                    fill_reg <= '0;
                    sum_reg  <= '0;
                    lq_reg   <= '0;
                    lf_reg   <= '0;
                    prev_reg <= zpd_pkg::SIG_ZERO;
                    rise_reg <= '0;
                end
            end else if (busy_reg) begin
                unique case (uw.jump)
                    zpd_pkg::JMP_IF_FILL: begin
                        step_reg <= filling ? uw.target : zpd_pkg::step_t'(step_reg + 1'b1);
                    end
                    zpd_pkg::JMP_END: begin
                        if (out_free) begin
                            busy_reg <= 1'b0;
                        end
                    end
                    default: begin
                        step_reg <= zpd_pkg::step_t'(step_reg + 1'b1);
                    end
                endcase
                // leaving sample out of the sums
                if (uw.sub_old) begin
                    sum_reg <= sum_reg - SSW'(old_reg);
                    lq_reg  <= lq_reg - p_reg[VW-1:0];
                end
                if (commit) begin
                    sum_reg     <= sum_reg + SSW'(v_reg);
                    lq_reg      <= lq_reg + p_reg[VW-1:0];
                    lf_reg      <= v_reg;
                    wptr_reg    <= wptr_next;
                    fill_reg    <= fill_next;
                    prev_reg    <= sig_reg;
                    rise_reg    <= rise_next;
                    m_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && !busy_reg) begin
            y_reg <= s_data.sample;
        end
        if (uw.mul_sel != zpd_pkg::MUL_NONE) begin
            p_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (uw.ld_ly) begin
            ly_reg <= L_S * SSW'(y_reg);
        end
        if (uw.ld_diff) begin
            diff_reg <= DW'(ly_reg) - DW'(sum_reg);
        end
        if (uw.ld_spread) begin
            // p holds sum^2 here: spread = L*sumsq - sum^2
            spread_reg <= lq_reg - p_reg[VW-1:0];
        end
        if (uw.ld_old) begin
            old_reg <= $signed(ram_rdata);
            lo_reg  <= L_S * SSW'($signed(ram_rdata));
        end
        if (uw.ld_f) begin
            f_reg <= $signed(f_wide[SW-1:0]);
        end
        if (uw.ld_lfb) begin
            lfb_reg <= L_S * SSW'(f_reg);
        end
        if (uw.ld_lhs) begin
            lhs_reg <= CW'(p_reg[2*DW-3:0]) << zpd_pkg::LHS_SHIFT;
        end
        if (uw.ld_rhs) begin
            rhs_reg <= CW'(p_reg[TW+HALF-1:0]);
        end
        if (uw.acc_rhs) begin
            rhs_reg <= rhs_reg + (CW'(p_reg[TW+HIW-1:0]) << HALF);
        end
        if (uw.clr_flag) begin
            flag_reg <= 1'b0;
        end
        if (uw.ld_flag) begin
            flag_reg <= (lhs_reg > rhs_reg);
        end
        if (uw.ld_new) begin
            v_reg <= flag_reg ? f_reg : y_reg;
            if (!flag_reg) begin
                sig_reg <= zpd_pkg::SIG_ZERO;
            end else if (diff_reg > 0) begin
                sig_reg <= zpd_pkg::SIG_POS;
            end else begin
                sig_reg <= zpd_pkg::SIG_NEG;
            end
        end
        if (commit) begin
            m_data_reg.peak_signal  <= sig_reg;
            m_data_reg.peak_count   <= rise_next;
            m_data_reg.window_ready <= (fill_next == FW'(WINDOW_LENGTH));
        end
    end

    zpd_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_LENGTH)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (wptr_reg),
        .wr_data (v_reg),
        .rd_en   (busy_reg && uw.rd_old),
        .rd_addr (wptr_reg),
        .rd_data (ram_rdata)
    );

endmodule

### bench/zpd_checker.sv
`timescale 1ns / 1ps
// zpd_checker: watches the sample, result and register ports of the peak
// detector, predicts every result and compares it. Depends on zpd_pkg.
module zpd_checker #(
    parameter int WINDOW_LENGTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  zpd_pkg::zpd_in_t                s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  zpd_pkg::zpd_out_t               m_data,
    input  logic                            cfg_wr_en,
    input  logic [zpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [zpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              pending,
    output int                              samples_seen,
    output int                              peaks_up,
    output int                              peaks_down,
    output int                              top_count
);

    // predicted block state
    logic signed [zpd_pkg::SAMPLE_WIDTH-1:0] window_vals [WINDOW_LENGTH];
    int                             wr_idx;
    int                             fill_cnt;
    longint                         win_sum;
    longint                         win_sqsum;
    longint                         last_val;
    logic signed [1:0]              prev_sig;
    int                             rises;
    logic [zpd_pkg::THRESHOLD_W-1:0] thr_reg;
    logic [zpd_pkg::INFLUENCE_W-1:0] infl_reg;

    zpd_pkg::zpd_out_t expected_results [$];
    zpd_pkg::zpd_out_t want;
    int       fails;
    int       n_samples;
    int       n_up;
    int       n_down;
    int       n_top;

    function automatic void clear_frame();
        wr_idx    = 0;
        fill_cnt  = 0;
        win_sum   = 0;
        win_sqsum = 0;
        last_val  = 0;
        prev_sig  = zpd_pkg::SIG_ZERO;
        rises     = 0;
    endfunction

    // One sample through the detector: band test on the window as it stands,
    // then the window update and the rise count.
    function automatic zpd_pkg::zpd_out_t score_sample(input zpd_pkg::zpd_in_t item);
        longint            y;
        longint            diff;
        longint            mag;
        longint            spread;
        longint            lhs;
        longint            rhs;
        longint            inf_w;
        longint            entering;
        longint            oldest;
        logic signed [1:0] sig;
        zpd_pkg::zpd_out_t res;
        y   = $signed(item.sample);
        sig = zpd_pkg::SIG_ZERO;
        if (item.frame_start) begin
            clear_frame();
        end
        entering = y;
        if (fill_cnt < WINDOW_LENGTH) begin
            fill_cnt++;
        end else begin
            // squared test, no root: 256*(L*y-S)^2 > thr^2*(L*Q-S^2)
            diff   = WINDOW_LENGTH * y - win_sum;
            mag    = (diff < 0) ? -diff : diff;
            lhs    = (16 * mag) * (16 * mag);
            spread = WINDOW_LENGTH * win_sqsum - win_sum * win_sum;
            rhs    = longint'(thr_reg) * longint'(thr_reg) * spread;
            if (lhs > rhs) begin
                sig      = (diff > 0) ? zpd_pkg::SIG_POS : zpd_pkg::SIG_NEG;
                inf_w    = (infl_reg > zpd_pkg::INFLUENCE_ONE) ? 256 : longint'(infl_reg);
                entering = (inf_w * y + (256 - inf_w) * last_val + 128) >>> 8;
            end
            oldest     = window_vals[wr_idx];
            win_sum   -= oldest;
            win_sqsum -= oldest * oldest;
        end
        win_sum            += entering;
        win_sqsum          += entering * entering;
        window_vals[wr_idx] = entering[zpd_pkg::SAMPLE_WIDTH-1:0];
        wr_idx              = (wr_idx + 1) % WINDOW_LENGTH;
        last_val            = entering;
        if (prev_sig == zpd_pkg::SIG_ZERO && sig == zpd_pkg::SIG_POS && rises < 65535) begin
            rises++;
        end
        prev_sig         = sig;
        res.peak_signal  = sig;
        res.peak_count   = rises[zpd_pkg::COUNT_WIDTH-1:0];
        res.window_ready = (fill_cnt >= WINDOW_LENGTH);
        return res;
    endfunction

    initial begin
        fails     = 0;
        n_samples = 0;
        n_up      = 0;
        n_down    = 0;
        n_top     = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            thr_reg  = zpd_pkg::THRESHOLD_RESET;
            infl_reg = zpd_pkg::INFLUENCE_RESET;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    zpd_pkg::REG_THRESHOLD:
                        thr_reg = cfg_wdata[zpd_pkg::THRESHOLD_W-1:0];
                    zpd_pkg::REG_INFLUENCE:
                        infl_reg = cfg_wdata[zpd_pkg::INFLUENCE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(score_sample(s_data));
                n_samples++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.peak_signal !== want.peak_signal) begin
                        $error("peak_signal: expected %0d, got %0d",
                               want.peak_signal, m_data.peak_signal);
                        fails++;
                    end
                    if (m_data.peak_count !== want.peak_count) begin
                        $error("peak_count: expected %0d, got %0d",
                               want.peak_count, m_data.peak_count);
                        fails++;
                    end
                    if (m_data.window_ready !== want.window_ready) begin
                        $error("window_ready: expected %0b, got %0b",
                               want.window_ready, m_data.window_ready);
                        fails++;
                    end
                    if (want.peak_signal == zpd_pkg::SIG_POS) n_up++;
                    if (want.peak_signal == zpd_pkg::SIG_NEG) n_down++;
                    if (int'(want.peak_count) > n_top) n_top = want.peak_count;
                end
            end
        end
        fail_count   <= fails;
        pending      <= expected_results.size();
        samples_seen <= n_samples;
        peaks_up     <= n_up;
        peaks_down   <= n_down;
        top_count    <= n_top;
    end

endmodule

### bench/tb_zscore_peak_detector.sv
`timescale 1ns / 1ps
// tb_zscore_peak_detector: stimulus, pacing and verdict for the z-score peak
// detector. Depends on zpd_pkg, zscore_peak_detector and zpd_checker.
module tb_zscore_peak_detector;

    localparam int WIN            = 32;
    localparam int RANDOM_SAMPLES = 1100;
    localparam int QUIET_LIMIT    = 500;   // cycles without any transfer
    localparam int SETTLE_CYCLES  = 12;    // a bit over one full-window sample
    localparam int SAMPLE_W       = zpd_pkg::SAMPLE_WIDTH;
    localparam int THR_W          = zpd_pkg::THRESHOLD_W;
    localparam int INFL_W         = zpd_pkg::INFLUENCE_W;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    zpd_pkg::zpd_in_t                s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    zpd_pkg::zpd_out_t               m_data;
    logic                            cfg_wr_en = 1'b0;
    logic [zpd_pkg::CFG_INDEX_W-1:0] cfg_index = zpd_pkg::REG_THRESHOLD;
    logic [zpd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int samples_seen;
    int peaks_up;
    int peaks_down;
    int top_count;

    // pacing knobs
    bit tx_bursty  = 1'b0;   // sender drops valid between bursts
    int burst_left = 0;
    bit rx_stalls  = 1'b0;   // receiver runs its own stall pattern
    int rx_hold    = 0;
    int quiet_cycles = 0;
    int reg_writes   = 0;
    int random_sent  = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    zscore_peak_detector #(
        .WINDOW_LENGTH(WIN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    zpd_checker #(
        .WINDOW_LENGTH(WIN)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .samples_seen(samples_seen),
        .peaks_up    (peaks_up),
        .peaks_down  (peaks_down),
        .top_count   (top_count)
    );

    // Receiver: alternating ready runs and stall runs of random length, or
    // always ready when stalls are off.
    always @(posedge aclk) begin
        if (!rx_stalls) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= !m_ready;
            rx_hold <= m_ready ? $urandom_range(0, 12) : $urandom_range(0, 9);
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One sample transfer. Valid goes (or stays) high here and the task
    // returns right after the edge that took the sample.
    task automatic send_item(input logic signed [SAMPLE_W-1:0] value,
                             input bit fs);
        zpd_pkg::zpd_in_t item;
        item.sample      = value;
        item.frame_start = fs;
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Burst pacing: after a burst ends, valid drops for a random gap so that
    // the next sample lands on a different step of the block's sequence.
    task automatic pace();
        if (tx_bursty) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                burst_left = $urandom_range(0, 6);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Wait for every outstanding result, then let the block settle. The
    // first edge makes sure the last transfer is already counted.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers, back to back; only called with the block idle.
    task automatic set_registers(input logic [THR_W-1:0] thr,
                                 input logic [INFL_W-1:0] infl);
        cfg_wr_en <= 1'b1;
        cfg_index <= zpd_pkg::REG_THRESHOLD;
        cfg_wdata <= zpd_pkg::CFG_DATA_W'(thr);
        @(posedge aclk);
        cfg_index <= zpd_pkg::REG_INFLUENCE;
        cfg_wdata <= infl;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_writes += 2;
    endtask

    // A frame of random samples. Most are a noisy baseline with occasional
    // spikes either way; some are flat but for rare small steps and some are
    // full-range noise. A rare stray frame_start breaks the frame early.
    task automatic random_frame(input int len);
        int base;
        int amp;
        int kind;
        int v;
        base = int'($urandom_range(0, 50000)) - 25000;
        amp  = $urandom_range(0, 1500);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
            if (kind == 0) begin
                v = int'($urandom_range(0, 65535)) - 32768;
            end else if (kind == 1) begin
                v = base;
                if ($urandom_range(0, 30) == 0) v += int'($urandom_range(0, 4)) - 2;
            end else begin
                v = base + int'($urandom_range(0, 2 * amp)) - amp;
                if ($urandom_range(0, 11) == 0) begin
                    if ($urandom_range(0, 1)) v += 4 * amp + int'($urandom_range(100, 12000));
                    else v -= 4 * amp + int'($urandom_range(100, 12000));
                end
            end
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_item(SAMPLE_W'(v), (i == 0) || ($urandom_range(0, 199) == 0));
            pace();
            random_sent++;
        end
    endtask

    initial begin
        int                level;
        int                phase;
        int                phase_sent;
        int                len;
        logic [THR_W-1:0]  thr;
        logic [INFL_W-1:0] infl;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Straight out of reset, reset register values, no frame_start: the
        // reset state has to behave as a fresh frame. Flat window, then
        // steps of one either way and both rails (zero spread flags them).
        tx_bursty = 1'b1;
        rx_stalls <= 1'b1;
        repeat (WIN) begin
            send_item(16'sd100, 1'b0);
            pace();
        end
        send_item(16'sd100, 1'b0);
        send_item(16'sd101, 1'b0);
        send_item(16'sd101, 1'b0);
        send_item(16'sd100, 1'b0);
        send_item(16'sd99, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(-16'sd32768, 1'b0);
        drain();

        // Zero threshold, influence of exactly one: window pinned at the
        // negative rail (largest sums), then the opposite rail.
        set_registers(8'd0, zpd_pkg::INFLUENCE_ONE);
        send_item(-16'sd32768, 1'b1);
        repeat (WIN - 1) send_item(-16'sd32768, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sd1, 1'b0);
        drain();

        // Top threshold and an influence above one (clamped): a flat window
        // still flags any change.
        set_registers(8'hFF, 9'd300);
        send_item(-16'sd5, 1'b1);
        repeat (WIN - 1) send_item(-16'sd5, 1'b0);
        send_item(16'sd20000, 1'b0);
        send_item(-16'sd5, 1'b0);
        send_item(16'sd20000, 1'b0);
        drain();

        // Alternating rails: widest spread, with a half-weight influence.
        set_registers(8'hFF, 9'd128);
        for (int i = 0; i < WIN; i++) begin
            send_item((i % 2) ? -16'sd32768 : 16'sh7FFF, i == 0);
        end
        send_item(16'sd0, 1'b0);
        send_item(-16'sd32768, 1'b0);
        drain();

        // Rise counting: a flat window with influence zero stays flat, so
        // level / level+1 pairs give one rise each.
        tx_bursty = 1'b0;
        rx_stalls <= 1'b0;
        set_registers(THR_W'($urandom_range(0, 255)), 9'd0);
        level = int'($urandom_range(0, 65534)) - 32768;
        send_item(SAMPLE_W'(level), 1'b1);
        repeat (WIN - 1) send_item(SAMPLE_W'(level), 1'b0);
        repeat (40) begin
            send_item(SAMPLE_W'(level), 1'b0);
            send_item(SAMPLE_W'(level + 1), 1'b0);
        end
        drain();

        // Random frames over a rotation of register settings that includes
        // both threshold extremes and influences of zero, one and above one.
        phase = 0;
        while (random_sent < RANDOM_SAMPLES) begin
            case (phase % 5)
                0: thr = 8'd0;
                1: thr = 8'hFF;
                2: thr = zpd_pkg::THRESHOLD_RESET;
                default: thr = THR_W'($urandom_range(4, 100));
            endcase
            case (phase % 4)
                0: infl = 9'd0;
                1: infl = zpd_pkg::INFLUENCE_ONE;
                2: infl = INFL_W'($urandom_range(257, 511));
                default: infl = INFL_W'($urandom_range(1, 255));
            endcase
            set_registers(thr, infl);
            phase_sent = 0;
            while (phase_sent < 200) begin
                tx_bursty = ($urandom_range(0, 3) != 0);
                rx_stalls <= ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 99) < 15) len = $urandom_range(1, WIN - 1);
                else len = WIN + $urandom_range(4, 70);
                random_frame(len);
                phase_sent += len;
            end
            drain();
            phase++;
        end

        $display("%0d samples over %0d register writes, %0d random", samples_seen,
                 reg_writes, random_sent);
        $display("%0d upward and %0d downward peaks, rise count up to %0d",
                 peaks_up, peaks_down, top_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
